// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// full property, sampled on the rising edge, off while in reset
`define LBES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbes assertion failed");

// same-cycle implication
`define LBES_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbes assertion failed");

`else

`define LBES_ASSERT(lbl, clk, rst_n, prop)
`define LBES_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/lbes_pkg.sv
// ----------------------------------------------------------------------------
// lbes_pkg
// shared types and constants of the led brightness effect sequencer
// ----------------------------------------------------------------------------
package lbes_pkg;

  // fade duration in ms: up to 4095 s * 1000 fits in 22 bits
  localparam int unsigned DUR_W       = 22;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned COLOR_COUNT = 9;
  localparam int unsigned COLOR_IDX_W = 4;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [7:0]  MAX_BRIGHT_RST = 8'd255;
  localparam logic [7:0]  FADE_STEP_RST  = 8'd5;
  localparam logic [15:0] BLINK_MS_RST   = 16'd500;
  localparam logic [15:0] PULSE_MS_RST   = 16'd30;
  localparam logic [11:0] FADE_S_RST     = 12'd10;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_ON        = 3'd1,
    MODE_BLINK     = 3'd2,
    MODE_PULSE     = 3'd3,
    MODE_FADE_ONCE = 3'd4,
    MODE_FADE_LOOP = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_COLOR_INDEX = 3'd1,
    REG_MAX_BRIGHT  = 3'd2,
    REG_FADE_STEP   = 3'd3,
    REG_BLINK_MS    = 3'd4,
    REG_PULSE_MS    = 3'd5,
    REG_FADE_S      = 3'd6,
    REG_FADE_PHASE  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PHASE,
    ST_EVAL,
    ST_DIV,
    ST_ROOT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam rgb_t PALETTE [16] = '{
    '{8'd0,   8'd128, 8'd0  },
    '{8'd255, 8'd255, 8'd0  },
    '{8'd255, 8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd255},
    '{8'd138, 8'd43,  8'd226},
    '{8'd255, 8'd69,  8'd0  },
    '{8'd0,   8'd255, 8'd255},
    '{8'd255, 8'd20,  8'd147},
    '{8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0  }
  };

endpackage

// File: rtl/led_brightness_effect_sequencer_unit.sv
// ----------------------------------------------------------------------------
// led_brightness_effect_sequencer_unit
// frame tick in, brightness and rgb color out, six effect modes
// ----------------------------------------------------------------------------
// Each input item is one frame tick with a millisecond timestamp; each tick
// gives one result item with the brightness and the rgb value of the chosen
// palette entry. Off, on, blink and pulse ticks skip the divider. Fade ticks
// still in progress run a restoring divider for elapsed*depth/duration, one
// quotient bit per cycle over DUR_W+clog2(ROOT_TABLE_DEPTH+1) bits (31 at the
// default depth), then a root table lookup. The first fade-loop tick after a
// non-color register write runs the divider again for phase mod seconds if
// the fade seconds are nonzero. The unit takes one item at a time; a finished
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_brightness_effect_sequencer_unit #(
  parameter int unsigned ROOT_TABLE_DEPTH = 256,
  parameter int unsigned TIME_BITS        = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [TIME_BITS-1:0]              now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        brightness_o,
  output logic [7:0]                        red_o,
  output logic [7:0]                        green_o,
  output logic [7:0]                        blue_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lbes_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lbes_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lbes_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned DUR_W = lbes_pkg::DUR_W;
  localparam int unsigned QB    = $clog2(ROOT_TABLE_DEPTH + 1);
  localparam int unsigned NUM_W = DUR_W + QB;
  localparam int unsigned CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  // round(256*(k/depth)^0.2), evaluated at elaboration
  function automatic logic [8:0] fifth_root(input int unsigned k);
    longint unsigned rhs, t, lhs;
    int unsigned     count;
    logic            stop;
    rhs   = 64'(k) << 45;
    count = 0;
    stop  = 1'b0;
    for (int unsigned r = 0; r <= 256; r++) begin
      if (!stop) begin
        t   = 64'(2 * r + 1);
        lhs = t * t * t * t * t * 64'(ROOT_TABLE_DEPTH);
        if (lhs <= rhs) begin
          count++;
        end else begin
          stop = 1'b1;
        end
      end
    end
    return 9'(count);
  endfunction

  logic [8:0] root_rom [ROOT_TABLE_DEPTH+1];

  for (genvar gk = 0; gk <= ROOT_TABLE_DEPTH; gk++) begin : g_root
    assign root_rom[gk] = fifth_root(gk);
  end

  // configuration registers
  lbes_pkg::mode_e                    mode_q;
  logic [lbes_pkg::COLOR_IDX_W-1:0]   color_q;
  logic [7:0]                         max_q, fstep_q;
  logic [15:0]                        blink_q, pulse_q;
  logic [11:0]                        fade_s_q, phase_q;

  logic                               cfg_we, cfg_set_pending;
  lbes_pkg::reg_idx_e                 cfg_idx;

  assign pready          = 1'b1;
  assign cfg_we          = psel && penable && pwrite;
  assign cfg_idx         = lbes_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_set_pending = cfg_we && (cfg_idx != lbes_pkg::REG_COLOR_INDEX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lbes_pkg::MODE_OFF;
      color_q  <= '0;
      max_q    <= lbes_pkg::MAX_BRIGHT_RST;
      fstep_q  <= lbes_pkg::FADE_STEP_RST;
      blink_q  <= lbes_pkg::BLINK_MS_RST;
      pulse_q  <= lbes_pkg::PULSE_MS_RST;
      fade_s_q <= lbes_pkg::FADE_S_RST;
      phase_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lbes_pkg::REG_MODE:        mode_q <= lbes_pkg::mode_e'(pwdata[2:0]);
        lbes_pkg::REG_COLOR_INDEX: begin
          // out-of-range color writes are dropped
          if (5'(pwdata[3:0]) < 5'(lbes_pkg::COLOR_COUNT)) begin
            color_q <= pwdata[3:0];
          end
        end
        lbes_pkg::REG_MAX_BRIGHT:  max_q    <= pwdata[7:0];
        lbes_pkg::REG_FADE_STEP:   fstep_q  <= pwdata[7:0];
        lbes_pkg::REG_BLINK_MS:    blink_q  <= pwdata[15:0];
        lbes_pkg::REG_PULSE_MS:    pulse_q  <= pwdata[15:0];
        lbes_pkg::REG_FADE_S:      fade_s_q <= pwdata[11:0];
        lbes_pkg::REG_FADE_PHASE:  phase_q  <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lbes_pkg::REG_MODE:        prdata = 32'(mode_q);
      lbes_pkg::REG_COLOR_INDEX: prdata = 32'(color_q);
      lbes_pkg::REG_MAX_BRIGHT:  prdata = 32'(max_q);
      lbes_pkg::REG_FADE_STEP:   prdata = 32'(fstep_q);
      lbes_pkg::REG_BLINK_MS:    prdata = 32'(blink_q);
      lbes_pkg::REG_PULSE_MS:    prdata = 32'(pulse_q);
      lbes_pkg::REG_FADE_S:      prdata = 32'(fade_s_q);
      lbes_pkg::REG_FADE_PHASE:  prdata = 32'(phase_q);
    endcase
  end

  // effect state and sequencer
  lbes_pkg::state_e        state_q, state_d;
  logic [TIME_BITS-1:0]    now_q, now_d;
  logic [7:0]              level_q, level_d;
  logic signed [8:0]       step_q, step_d;
  logic [TIME_BITS-1:0]    last_q, last_d;
  logic [TIME_BITS-1:0]    fstart_q, fstart_d;
  logic                    pending_q, pending_d;
  logic [8:0]              root_q, root_d;
  logic                    load_out;

  logic                    out_valid_q;
  logic [7:0]              bright_q;
  lbes_pkg::rgb_t          rgb_q;

  logic                    div_start;
  logic [NUM_W-1:0]        div_num, div_quo;
  logic [DUR_W-1:0]        div_den, div_rem;
  lbes_pkg::div_stat_t     div_stat;

  logic [DUR_W-1:0]        duration, phase_ms, fade_el;
  logic [TIME_BITS-1:0]    elapsed, since_change;
  logic [CMP_W-1:0]        elapsed_x, dur_x;
  logic [7:0]              pulse_sum;
  logic [QB-1:0]           root_idx;
  logic [15:0]             fade_prod;
  logic                    div_wait, done_held;

  assign duration     = DUR_W'(fade_s_q) * DUR_W'(lbes_pkg::MS_PER_S);
  assign phase_ms     = div_rem * DUR_W'(lbes_pkg::MS_PER_S);
  assign elapsed      = now_q - fstart_q;
  assign since_change = now_q - last_q;
  assign elapsed_x    = CMP_W'(elapsed);
  assign dur_x        = CMP_W'(duration);
  assign pulse_sum    = level_q + step_q[7:0];
  assign root_idx     = (div_quo > NUM_W'(ROOT_TABLE_DEPTH)) ? QB'(ROOT_TABLE_DEPTH)
                                                             : div_quo[QB-1:0];
  // max*root + 255 stays within 16 bits since root <= 256
  assign fade_prod    = 16'(max_q) * 16'(root_q) + 16'd255;

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    level_d   = level_q;
    step_d    = step_q;
    last_d    = last_q;
    fstart_d  = fstart_q;
    pending_d = pending_q;
    root_d    = root_q;
    load_out  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    fade_el   = elapsed_x[DUR_W-1:0];

    unique case (state_q)
      lbes_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          now_d   = now_ms_i;
          state_d = lbes_pkg::ST_START;
        end
      end

      lbes_pkg::ST_START: begin
        state_d = lbes_pkg::ST_EVAL;
        if (pending_q) begin
          pending_d = 1'b0;
          case (mode_q)
            lbes_pkg::MODE_OFF:   level_d = '0;
            lbes_pkg::MODE_ON:    level_d = max_q;
            lbes_pkg::MODE_BLINK: level_d = max_q;
            lbes_pkg::MODE_PULSE: begin
              level_d = '0;
              step_d  = $signed({1'b0, fstep_q});
            end
            lbes_pkg::MODE_FADE_ONCE: begin
              level_d  = max_q;
              fstart_d = now_q;
              step_d   = 9'sd1;
              last_d   = '0;
            end
            lbes_pkg::MODE_FADE_LOOP: begin
              step_d = $signed({1'b0, fstep_q});
              if (fade_s_q == '0) begin
                fstart_d = now_q;
              end else begin
                // phase mod seconds on the shared divider
                div_start = 1'b1;
                div_num   = NUM_W'(phase_q);
                div_den   = DUR_W'(fade_s_q);
                state_d   = lbes_pkg::ST_PHASE;
              end
            end
            default: ;
          endcase
        end
      end

      lbes_pkg::ST_PHASE: begin
        if (div_stat.done) begin
          fstart_d = TIME_BITS'(CMP_W'(now_q) - CMP_W'(phase_ms));
          state_d  = lbes_pkg::ST_EVAL;
        end
      end

      lbes_pkg::ST_EVAL: begin
        state_d = lbes_pkg::ST_DONE;
        case (mode_q)
          lbes_pkg::MODE_OFF: level_d = '0;
          lbes_pkg::MODE_ON:  level_d = max_q;
          lbes_pkg::MODE_BLINK: begin
            if (since_change > TIME_BITS'(blink_q)) begin
              level_d = (level_q == '0) ? max_q : '0;
              last_d  = now_q;
            end
          end
          lbes_pkg::MODE_PULSE: begin
            if (since_change > TIME_BITS'(pulse_q)) begin
              level_d = pulse_sum;
              if ((pulse_sum == '0) || (pulse_sum >= max_q)) begin
                step_d = -step_q;
              end
              last_d = now_q;
            end
          end
          lbes_pkg::MODE_FADE_ONCE: begin
            if (level_q != '0) begin
              last_d = now_q;
              if (elapsed_x >= dur_x) begin
                level_d = '0;
              end else begin
                div_start = 1'b1;
                div_num   = NUM_W'(fade_el) * NUM_W'(ROOT_TABLE_DEPTH);
                div_den   = duration;
                state_d   = lbes_pkg::ST_DIV;
              end
            end
          end
          lbes_pkg::MODE_FADE_LOOP: begin
            last_d = now_q;
            // restart the loop once the duration is passed
            if (elapsed_x > dur_x) begin
              fstart_d = now_q;
              fade_el  = '0;
            end
            if (duration == '0) begin
              level_d = '0;
            end else begin
              div_start = 1'b1;
              div_num   = NUM_W'(fade_el) * NUM_W'(ROOT_TABLE_DEPTH);
              div_den   = duration;
              state_d   = lbes_pkg::ST_DIV;
            end
          end
          default: ;
        endcase
      end

      lbes_pkg::ST_DIV: begin
        if (div_stat.done) begin
          root_d  = root_rom[root_idx];
          state_d = lbes_pkg::ST_ROOT;
        end
      end

      lbes_pkg::ST_ROOT: begin
        level_d = max_q - fade_prod[15:8];
        state_d = lbes_pkg::ST_DONE;
      end

      lbes_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = lbes_pkg::ST_IDLE;
        end
      end

      default: state_d = lbes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lbes_pkg::ST_IDLE;
      level_q   <= '0;
      step_q    <= $signed({1'b0, lbes_pkg::FADE_STEP_RST});
      last_q    <= '0;
      fstart_q  <= '0;
      pending_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      step_q    <= step_d;
      last_q    <= last_d;
      fstart_q  <= fstart_d;
      pending_q <= cfg_set_pending ? 1'b1 : pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    root_q <= root_d;
    if (load_out) begin
      bright_q <= level_q;
      rgb_q    <= lbes_pkg::PALETTE[color_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  lbes_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DUR_W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_num),
    .divisor_i   (div_den),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign in_stall_o   = (state_q != lbes_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign brightness_o = bright_q;
  assign red_o        = rgb_q.red;
  assign green_o      = rgb_q.green;
  assign blue_o       = rgb_q.blue;

  assign div_wait  = (state_q == lbes_pkg::ST_DIV) || (state_q == lbes_pkg::ST_PHASE);
  assign done_held = (state_q == lbes_pkg::ST_DONE) && out_valid_q && out_stall_i;

  `LBES_IMPLIES(a_div_start_free, clk_i, rst_ni, div_start, !div_stat.busy)
  `LBES_IMPLIES(a_div_done_wait, clk_i, rst_ni, div_stat.done, div_wait)
  `LBES_ASSERT(a_done_holds, clk_i, rst_ni, done_held |=> (state_q == lbes_pkg::ST_DONE))

endmodule

// File: rtl/lbes_divider.sv
// ----------------------------------------------------------------------------
// lbes_divider
// restoring divider, one quotient bit per cycle, quotient and remainder out
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbes_divider #(
  parameter int unsigned NUM_W = 31,
  parameter int unsigned DEN_W = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_W-1:0]     dividend_i,
  input  logic [DEN_W-1:0]     divisor_i,
  output lbes_pkg::div_stat_t  stat_o,
  output logic [NUM_W-1:0]     quotient_o,
  output logic [DEN_W-1:0]     remainder_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;

  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  `LBES_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q)
  `LBES_IMPLIES(a_rem_range, clk_i, rst_ni, done_q, rem_q < den_q)
  `LBES_IMPLIES(a_busy_end, clk_i, rst_ni, $fell(busy_q), done_q)

endmodule

// File: test/led_brightness_effect_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// led_brightness_effect_sequencer_unit_tb
// self-checking bench for the led brightness effect sequencer
// ----------------------------------------------------------------------------
// Frame ticks go in through the valid/stall port and the effect registers are
// set over the apb port while the unit is idle. A behavioral copy of the
// sequencer tracks level, pulse direction, last change time and fade start,
// and predicts brightness and color for every accepted tick. Each result item
// is checked against the oldest prediction. Directed tests cover the corner
// cases of every mode; random sequences follow, with random gaps on the
// input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module led_brightness_effect_sequencer_unit_tb;

  localparam int unsigned RANDOM_TICKS = 1150;
  localparam int unsigned MS_PER_SEC   = 1000;
  localparam int unsigned HUE_COUNT    = 9;
  localparam int unsigned ROOT_DEPTH   = 256;
  localparam int unsigned ADDR_W       = lbes_pkg::APB_ADDR_W;
  localparam int unsigned DATA_W       = lbes_pkg::APB_DATA_W;
  localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE_7 = 3'd7;
  localparam int unsigned REG_BITS [8] = '{3, 4, 8, 8, 16, 16, 12, 12};
  localparam logic [23:0] HUE_TAB [HUE_COUNT] = '{
    24'h008000, 24'hFFFF00, 24'hFF0000, 24'h0000FF, 24'hFFFFFF,
    24'h8A2BE2, 24'hFF4500, 24'h00FFFF, 24'hFF1493
  };

  typedef struct packed {
    logic [7:0] bright;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } frame_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [31:0] now_ms_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  brightness_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr  = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  led_brightness_effect_sequencer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .brightness_o (brightness_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // register shadow
  logic [2:0]  cfg_mode   = lbes_pkg::MODE_OFF;
  logic [3:0]  cfg_color  = '0;
  logic [7:0]  cfg_max    = lbes_pkg::MAX_BRIGHT_RST;
  logic [7:0]  cfg_step   = lbes_pkg::FADE_STEP_RST;
  logic [15:0] cfg_blink  = lbes_pkg::BLINK_MS_RST;
  logic [15:0] cfg_pulse  = lbes_pkg::PULSE_MS_RST;
  logic [11:0] cfg_fade_s = lbes_pkg::FADE_S_RST;
  logic [11:0] cfg_phase  = '0;

  // effect state
  logic [7:0]        lvl      = '0;
  logic signed [8:0] step_dir = 9'sd5;
  logic [31:0]       last_ms  = '0;
  logic [31:0]       fade_t0  = '0;
  logic              init_due = 1'b1;

  logic [8:0]  root_tab [0:ROOT_DEPTH];
  frame_t      frames_due [$];
  int          err_cnt     = 0;
  int          ticks_sent  = 0;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int          hold_left   = 0;
  logic [31:0] t_ms        = '0;

  // round(256 * (k/depth)^0.2): count r with (2r+1)^5 * depth <= k * 2^45
  function automatic logic [8:0] fifth_root_q8(input int unsigned k);
    longint unsigned lim;
    longint unsigned t;
    logic [8:0]      cnt;
    int              r;
    lim = 64'(k) << 45;
    cnt = '0;
    for (r = 0; r <= 256; r++) begin
      t = 64'(2 * r + 1);
      if (t * t * t * t * t * 64'(ROOT_DEPTH) > lim) break;
      cnt++;
    end
    return cnt;
  endfunction

  function automatic logic [7:0] fade_curve(input logic [31:0] elapsed,
                                            input logic [31:0] dur);
    logic [63:0] n;
    logic [31:0] acc;
    if (dur == 0) return '0;
    n = (64'(elapsed) * 64'(ROOT_DEPTH)) / 64'(dur);
    if (n > 64'(ROOT_DEPTH)) n = 64'(ROOT_DEPTH);
    acc = 32'(cfg_max) * 32'(root_tab[n]) + 32'd255;
    return cfg_max - acc[15:8];
  endfunction

  task automatic predict_frame(input logic [31:0] now);
    logic [31:0] dur;
    logic [31:0] elapsed;
    logic [31:0] phase;
    logic [7:0]  b;
    frame_t      f;
    dur = 32'(cfg_fade_s) * MS_PER_SEC;
    if (init_due) begin
      case (cfg_mode) inside
        lbes_pkg::MODE_OFF: lvl = '0;
        lbes_pkg::MODE_ON, lbes_pkg::MODE_BLINK: lvl = cfg_max;
        lbes_pkg::MODE_PULSE: begin
          lvl = '0;
          step_dir = $signed({1'b0, cfg_step});
        end
        lbes_pkg::MODE_FADE_ONCE: begin
          lvl = cfg_max;
          fade_t0 = now;
          step_dir = 9'sd1;
          last_ms = '0;
        end
        lbes_pkg::MODE_FADE_LOOP: begin
          phase = (cfg_fade_s != 0) ? 32'(cfg_phase % cfg_fade_s) : '0;
          fade_t0 = now - phase * MS_PER_SEC;
          step_dir = $signed({1'b0, cfg_step});
        end
        default: ;
      endcase
      init_due = 1'b0;
    end
    b = lvl;
    case (cfg_mode)
      lbes_pkg::MODE_OFF: b = '0;
      lbes_pkg::MODE_ON: b = cfg_max;
      lbes_pkg::MODE_BLINK: begin
        if (now - last_ms > 32'(cfg_blink)) begin
          b = (b == 0) ? cfg_max : 8'd0;
          last_ms = now;
        end
      end
      lbes_pkg::MODE_PULSE: begin
        if (now - last_ms > 32'(cfg_pulse)) begin
          b = b + step_dir[7:0];
          if (b == 0 || b >= cfg_max) step_dir = -step_dir;
          last_ms = now;
        end
      end
      lbes_pkg::MODE_FADE_ONCE: begin
        // once the fade has reached zero it stays there
        if (lvl != 0) begin
          elapsed = now - fade_t0;
          b = (elapsed >= dur) ? 8'd0 : fade_curve(elapsed, dur);
          last_ms = now;
        end
      end
      lbes_pkg::MODE_FADE_LOOP: begin
        elapsed = now - fade_t0;
        if (elapsed > dur) begin
          fade_t0 = now;
          elapsed = '0;
        end
        b = fade_curve(elapsed, dur);
        last_ms = now;
      end
      default: ;
    endcase
    lvl = b;
    f.bright = b;
    {f.red, f.green, f.blue} = HUE_TAB[cfg_color];
    frames_due.push_back(f);
  endtask

  function automatic int idle_len(input int pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    return ($urandom_range(9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  task automatic send_tick(input logic [31:0] now);
    int gap;
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(now);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input lbes_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] data;
    data = value;
    // junk above the register width must be dropped
    if ($urandom_range(3) == 0) data = data | ($urandom() << REG_BITS[idx]);
    wait_drained();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lbes_pkg::REG_MODE:        cfg_mode = data[2:0];
      lbes_pkg::REG_COLOR_INDEX: if (data[3:0] < HUE_COUNT) cfg_color = data[3:0];
      lbes_pkg::REG_MAX_BRIGHT:  cfg_max = data[7:0];
      lbes_pkg::REG_FADE_STEP:   cfg_step = data[7:0];
      lbes_pkg::REG_BLINK_MS:    cfg_blink = data[15:0];
      lbes_pkg::REG_PULSE_MS:    cfg_pulse = data[15:0];
      lbes_pkg::REG_FADE_S:      cfg_fade_s = data[11:0];
      lbes_pkg::REG_FADE_PHASE:  cfg_phase = data[11:0];
      default: ;
    endcase
    if (idx != lbes_pkg::REG_COLOR_INDEX) init_due = 1'b1;
  endtask

  // output side back-pressure
  always @(posedge clk_i) begin
    int n;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      n = idle_len(stall_pct);
      if (n > 0) begin
        hold_left = n - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_due.size() == 0) begin
        $error("result item with no prediction pending");
        err_cnt++;
      end else begin
        want = frames_due.pop_front();
        if (brightness_o !== want.bright) begin
          $error("brightness: expected %0d, got %0d", want.bright, brightness_o);
          err_cnt++;
        end
        if (red_o !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red_o);
          err_cnt++;
        end
        if (green_o !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green_o);
          err_cnt++;
        end
        if (blue_o !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_tick(32'd0);
    send_tick(32'hFFFF_FFFF);
  endtask

  task automatic test_on_and_colors();
    write_reg(lbes_pkg::REG_MODE, 32'(lbes_pkg::MODE_ON));
    write_reg(lbes_pkg::REG_COLOR_INDEX, 32'd8);
    send_tick(32'd5);
    // out of range color is dropped
    write_reg(lbes_pkg::REG_COLOR_INDEX, 32'd15);
    send_tick(32'd6);
    write_reg(lbes_pkg::REG_MAX_BRIGHT, 32'd0);
    send_tick(32'd7);
    write_reg(lbes_pkg::REG_MAX_BRIGHT, 32'd255);
  endtask

  task automatic test_blink();
    write_reg(lbes_pkg::REG_BLINK_MS, 32'd0);
    write_reg(lbes_pkg::REG_MODE, 32'(lbes_pkg::MODE_BLINK));
    send_tick(32'd100);
    send_tick(32'd100);
    send_tick(32'd101);
    write_reg(lbes_pkg::REG_BLINK_MS, 32'd65535);
    send_tick(32'd65636);
    send_tick(32'd65637);
  endtask

  task automatic test_pulse();
    write_reg(lbes_pkg::REG_FADE_STEP, 32'd255);
    write_reg(lbes_pkg::REG_PULSE_MS, 32'd0);
    write_reg(lbes_pkg::REG_MODE, 32'(lbes_pkg::MODE_PULSE));
    send_tick(32'd1);
    send_tick(32'd2);
    send_tick(32'd3);
    write_reg(lbes_pkg::REG_FADE_STEP, 32'd0);
    send_tick(32'd4);
  endtask

  task automatic test_fade_once();
    write_reg(lbes_pkg::REG_FADE_S, 32'd1);
    write_reg(lbes_pkg::REG_MODE, 32'(lbes_pkg::MODE_FADE_ONCE));
    send_tick(32'd1000);
    send_tick(32'd1500);
    send_tick(32'd2000);
    send_tick(32'd2001);
    write_reg(lbes_pkg::REG_FADE_S, 32'd0);
    send_tick(32'd3000);
  endtask

  task automatic test_fade_loop();
    write_reg(lbes_pkg::REG_FADE_S, 32'd2);
    write_reg(lbes_pkg::REG_FADE_PHASE, 32'd5);
    write_reg(lbes_pkg::REG_MODE, 32'(lbes_pkg::MODE_FADE_LOOP));
    send_tick(32'd0);
    send_tick(32'd1000);
    send_tick(32'd1001);
    write_reg(lbes_pkg::REG_FADE_PHASE, 32'd4095);
    send_tick(32'd5000);
    write_reg(lbes_pkg::REG_FADE_S, 32'd0);
    send_tick(32'd6000);
  endtask

  task automatic test_unused_modes();
    write_reg(lbes_pkg::REG_MODE, 32'(MODE_SPARE_6));
    send_tick(32'd7000);
    write_reg(lbes_pkg::REG_MODE, 32'(MODE_SPARE_7));
    send_tick(32'd7001);
  endtask

  function automatic logic [31:0] pick_value(input lbes_pkg::reg_idx_e idx);
    int r;
    r = $urandom_range(11);
    case (idx) inside
      lbes_pkg::REG_MODE: return (r < 9) ? $urandom_range(2, 5) : $urandom_range(0, 7);
      lbes_pkg::REG_COLOR_INDEX: return $urandom_range(0, 15);
      lbes_pkg::REG_MAX_BRIGHT: begin
        if (r < 3) return (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : 32'd255;
        return $urandom_range(1, 255);
      end
      lbes_pkg::REG_FADE_STEP: begin
        if (r < 3) return (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : 32'd255;
        return (r < 6) ? $urandom_range(1, 255) : $urandom_range(1, 60);
      end
      lbes_pkg::REG_BLINK_MS, lbes_pkg::REG_PULSE_MS: begin
        if (r < 2) return (r == 0) ? 32'd0 : 32'd65535;
        return (r < 4) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
      end
      lbes_pkg::REG_FADE_S: begin
        if (r == 0) return ($urandom_range(1) == 0) ? 32'd0 : 32'd4095;
        if (r == 1) return $urandom_range(0, 4095);
        return $urandom_range(1, 4);
      end
      lbes_pkg::REG_FADE_PHASE: begin
        return (r < 2) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
      end
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] tick_pace();
    case (cfg_mode) inside
      lbes_pkg::MODE_BLINK: return 32'(cfg_blink) + 1;
      lbes_pkg::MODE_PULSE: return 32'(cfg_pulse) + 1;
      lbes_pkg::MODE_FADE_ONCE, lbes_pkg::MODE_FADE_LOOP: begin
        return 32'(cfg_fade_s) * MS_PER_SEC / 6 + 1;
      end
      default: return 32'd1000;
    endcase
  endfunction

  task automatic test_random_sequences();
    int          stop_at;
    int          burst;
    int          i;
    int          r;
    logic [31:0] pace;
    stop_at = ticks_sent + RANDOM_TICKS;
    t_ms = $urandom();
    while (ticks_sent < stop_at) begin
      for (i = 1; i < 8; i++) begin
        if ($urandom_range(2) == 0) begin
          write_reg(lbes_pkg::reg_idx_e'(i), pick_value(lbes_pkg::reg_idx_e'(i)));
        end
      end
      write_reg(lbes_pkg::REG_MODE, pick_value(lbes_pkg::REG_MODE));
      r = $urandom_range(3);
      gap_pct   = (r == 0) ? 0 : (r == 1) ? 10 : (r == 2) ? 30 : 60;
      r = $urandom_range(3);
      stall_pct = (r == 0) ? 0 : (r == 1) ? 10 : (r == 2) ? 30 : 60;
      pace = tick_pace();
      // sometimes start just below the timestamp wrap
      if ($urandom_range(4) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * pace + 10);
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        r = $urandom_range(19);
        if (r == 0) t_ms = $urandom();
        else if (r < 4) t_ms = t_ms + pace - $urandom_range(1);
        else t_ms = t_ms + $urandom_range(0, 2 * pace + 1);
        send_tick(t_ms);
        if ($urandom_range(30) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    int k;
    for (k = 0; k <= ROOT_DEPTH; k++) root_tab[k] = fifth_root_q8(k);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_on_and_colors();
    test_blink();
    test_pulse();
    test_fade_once();
    test_fade_loop();
    test_unused_modes();
    test_random_sequences();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
